// File: hdl/rmea_pkg.sv
package rmea_pkg;

	// Fixed-point constants
	localparam logic signed [16:0] ONE_Q14     = 17'sd16384;
	localparam logic signed [16:0] NEG_ONE_Q14 = -17'sd16384;
	localparam logic [14:0]        PI_Q13      = 15'd25736;
	localparam logic signed [31:0] PI_Q24      = 32'sd52707179;
	localparam logic signed [31:0] HALF_PI_Q24 = 32'sd26353589;
	localparam logic [29:0]        SQ_FULL     = 30'h1000_0000;

	// Square root row: radicand up to 2^28, so 15 two-bit steps
	localparam int SQRT_STEPS = 15;
	localparam int SQ_W       = 30;

	// Divider row: 16 quotient bits; a quotient of 2^15 or more saturates
	localparam int DIV_STEPS = 16;
	localparam int DIV_REM_W = 47;
	localparam int DIV_DEN_W = 32;
	localparam int DIV_NUM_W = 33;

	// Arctangent of 2^-i in Q.24
	localparam int ATAN_LEN = 24;
	localparam logic [23:0] ATAN_Q24 [ATAN_LEN] = '{
		24'd13176795, 24'd7778716, 24'd4110060, 24'd2086331,
		24'd1047214, 24'd524117, 24'd262123, 24'd131069,
		24'd65536, 24'd32768, 24'd16384, 24'd8192,
		24'd4096, 24'd2048, 24'd1024, 24'd512,
		24'd256, 24'd128, 24'd64, 24'd32,
		24'd16, 24'd8, 24'd4, 24'd2
	};

	typedef struct packed {
		logic signed [15:0] r00;
		logic signed [15:0] r01;
		logic signed [15:0] r02;
		logic signed [15:0] r12;
		logic signed [15:0] r20;
		logic signed [15:0] r21;
		logic signed [15:0] r22;
	} matrix_t;

	typedef struct packed {
		logic signed [15:0] angle_a;
		logic [14:0]        angle_b;
		logic signed [15:0] angle_c;
		logic               degenerate;
	} angles_t;

	typedef struct packed {
		logic signed [16:0] co;
		logic               neg;
	} pair_t;

	// Clamp a (cos, sin) pair; the order of the checks matters
	function automatic pair_t pair_clamp(input logic signed [16:0] co_i,
		input logic signed [16:0] si_i);
		logic signed [16:0] co;
		logic signed [16:0] si;
		pair_t r;
		co = co_i;
		si = si_i;
		if (co > ONE_Q14) begin
			co = ONE_Q14;
			si = '0;
		end
		if (co < NEG_ONE_Q14) begin
			co = NEG_ONE_Q14;
			si = '0;
		end
		if (si > ONE_Q14) begin
			si = ONE_Q14;
			co = '0;
		end
		if (si < NEG_ONE_Q14) begin
			si = NEG_ONE_Q14;
			co = '0;
		end
		r.co = co;
		r.neg = si[16];
		return r;
	endfunction

endpackage

// File: hdl/rmea_sqrt_cell.sv
module rmea_sqrt_cell #(
	parameter int K     = 0,
	parameter int TAG_W = 1
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      vld_i,
	input  logic [rmea_pkg::SQ_W-1:0] rad_i,
	input  logic [rmea_pkg::SQ_W-1:0] root_i,
	input  logic [TAG_W-1:0]          tag_i,
	output logic                      vld_o,
	output logic [rmea_pkg::SQ_W-1:0] rad_o,
	output logic [rmea_pkg::SQ_W-1:0] root_o,
	output logic [TAG_W-1:0]          tag_o
);

	localparam logic [rmea_pkg::SQ_W-1:0] BIT = rmea_pkg::SQ_W'(1) << (2 * K);

	logic                      vld_q;
	logic [rmea_pkg::SQ_W-1:0] rad_q;
	logic [rmea_pkg::SQ_W-1:0] root_q;
	logic [TAG_W-1:0]          tag_q;
	logic [rmea_pkg::SQ_W-1:0] trial;
	logic                      fits;

	// Try the next root bit against the remaining radicand
	assign trial = root_i + BIT;
	assign fits  = rad_i >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_i;
		end
	end

	// Advance one step of the digit-by-digit root
	always_ff @(posedge clk) begin
		if (en) begin
			rad_q  <= fits ? rad_i - trial : rad_i;
			root_q <= fits ? (root_i >> 1) + BIT : root_i >> 1;
			tag_q  <= tag_i;
		end
	end

	assign vld_o  = vld_q;
	assign rad_o  = rad_q;
	assign root_o = root_q;
	assign tag_o  = tag_q;

endmodule

// File: hdl/rmea_cordic_cell.sv
module rmea_cordic_cell #(
	parameter int IDX   = 0,
	parameter int TAG_W = 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               vld_i,
	input  logic signed [31:0] x_i,
	input  logic signed [31:0] y_i,
	input  logic signed [31:0] z_i,
	input  logic [TAG_W-1:0]   tag_i,
	output logic               vld_o,
	output logic signed [31:0] x_o,
	output logic signed [31:0] y_o,
	output logic signed [31:0] z_o,
	output logic [TAG_W-1:0]   tag_o
);

	localparam logic signed [31:0] ANG = $signed({8'd0, rmea_pkg::ATAN_Q24[IDX]});

	logic               vld_q;
	logic signed [31:0] x_q;
	logic signed [31:0] y_q;
	logic signed [31:0] z_q;
	logic [TAG_W-1:0]   tag_q;
	logic signed [31:0] xs;
	logic signed [31:0] ys;

	assign xs = x_i >>> IDX;
	assign ys = y_i >>> IDX;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_i;
		end
	end

	// Rotate toward the x axis by the sign of y
	always_ff @(posedge clk) begin
		if (en) begin
			if (!y_i[31]) begin
				x_q <= x_i + ys;
				y_q <= y_i - xs;
				z_q <= z_i + ANG;
			end else begin
				x_q <= x_i - ys;
				y_q <= y_i + xs;
				z_q <= z_i - ANG;
			end
			tag_q <= tag_i;
		end
	end

	assign vld_o = vld_q;
	assign x_o   = x_q;
	assign y_o   = y_q;
	assign z_o   = z_q;
	assign tag_o = tag_q;

endmodule

// File: hdl/rmea_div_cell.sv
module rmea_div_cell #(
	parameter int SH    = 0,
	parameter int TAG_W = 1
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                vld_i,
	input  logic [rmea_pkg::DIV_REM_W-1:0]      rem_i,
	input  logic [rmea_pkg::DIV_DEN_W-1:0]      den_i,
	input  logic [rmea_pkg::DIV_STEPS-1:0]      quo_i,
	input  logic [TAG_W-1:0]                    tag_i,
	output logic                                vld_o,
	output logic [rmea_pkg::DIV_REM_W-1:0]      rem_o,
	output logic [rmea_pkg::DIV_DEN_W-1:0]      den_o,
	output logic [rmea_pkg::DIV_STEPS-1:0]      quo_o,
	output logic [TAG_W-1:0]                    tag_o
);

	logic                              vld_q;
	logic [rmea_pkg::DIV_REM_W-1:0]    rem_q;
	logic [rmea_pkg::DIV_DEN_W-1:0]    den_q;
	logic [rmea_pkg::DIV_STEPS-1:0]    quo_q;
	logic [TAG_W-1:0]                  tag_q;
	logic [rmea_pkg::DIV_REM_W-1:0]    dsh;
	logic                              fits;
	logic [rmea_pkg::DIV_STEPS-1:0]    quo_n;

	// Compare the remainder with the shifted divisor
	assign dsh  = rmea_pkg::DIV_REM_W'(den_i) << SH;
	assign fits = rem_i >= dsh;

	always_comb begin
		quo_n = quo_i;
		quo_n[SH] = fits;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q <= fits ? rem_i - dsh : rem_i;
			den_q <= den_i;
			quo_q <= quo_n;
			tag_q <= tag_i;
		end
	end

	assign vld_o = vld_q;
	assign rem_o = rem_q;
	assign den_o = den_q;
	assign quo_o = quo_q;
	assign tag_o = tag_q;

endmodule

// File: hdl/rmea_divider.sv
module rmea_divider #(
	parameter int TAG_W = 1
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  en,
	input  logic                                  vld_i,
	input  logic signed [rmea_pkg::DIV_NUM_W-1:0] num_i,
	input  logic [rmea_pkg::DIV_DEN_W-1:0]        den_i,
	input  logic [TAG_W-1:0]                      tag_i,
	output logic                                  vld_o,
	output logic signed [16:0]                    quo_o,
	output logic [TAG_W-1:0]                      tag_o
);

	localparam int N   = rmea_pkg::DIV_STEPS;
	localparam int CTW = TAG_W + 3;

	logic [rmea_pkg::DIV_NUM_W-1:0] mag;
	logic [rmea_pkg::DIV_REM_W-1:0] num_sh;
	logic [rmea_pkg::DIV_REM_W-1:0] den_top;

	logic                            vld_s1;
	logic [rmea_pkg::DIV_REM_W-1:0]  rem_s1;
	logic [rmea_pkg::DIV_DEN_W-1:0]  den_s1;
	logic [CTW-1:0]                  tag_s1;

	logic                            vld_c [N+1];
	logic [rmea_pkg::DIV_REM_W-1:0]  rem_c [N+1];
	logic [rmea_pkg::DIV_DEN_W-1:0]  den_c [N+1];
	logic [N-1:0]                    quo_c [N+1];
	logic [CTW-1:0]                  tag_c [N+1];

	logic                            neg_e;
	logic                            zero_e;
	logic                            sat_e;
	logic [16:0]                     mag_e;

	logic                            vld_s3;
	logic signed [16:0]              quo_s3;
	logic [TAG_W-1:0]                tag_s3;

	// Magnitude of numerator times one, and the saturation test
	assign mag     = num_i[rmea_pkg::DIV_NUM_W-1] ? -num_i : num_i;
	assign num_sh  = rmea_pkg::DIV_REM_W'(mag) << 14;
	assign den_top = rmea_pkg::DIV_REM_W'(den_i) << N - 1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s1 <= num_sh;
			den_s1 <= den_i;
			tag_s1 <= {num_i[rmea_pkg::DIV_NUM_W-1], den_i == '0, num_sh >= den_top, tag_i};
		end
	end

	assign vld_c[0] = vld_s1;
	assign rem_c[0] = rem_s1;
	assign den_c[0] = den_s1;
	assign quo_c[0] = '0;
	assign tag_c[0] = tag_s1;

	// Restoring division, one quotient bit per cell, high bit first
	for (genvar g = 0; g < N; g++) begin : g_cell
		rmea_div_cell #(
			.SH    (N - 1 - g),
			.TAG_W (CTW)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.vld_i  (vld_c[g]),
			.rem_i  (rem_c[g]),
			.den_i  (den_c[g]),
			.quo_i  (quo_c[g]),
			.tag_i  (tag_c[g]),
			.vld_o  (vld_c[g+1]),
			.rem_o  (rem_c[g+1]),
			.den_o  (den_c[g+1]),
			.quo_o  (quo_c[g+1]),
			.tag_o  (tag_c[g+1])
		);
	end

	// Apply zero divisor, saturation and sign
	assign {neg_e, zero_e, sat_e} = tag_c[N][CTW-1:TAG_W];

	always_comb begin
		if (zero_e) begin
			mag_e = '0;
		end else if (sat_e) begin
			mag_e = 17'd32768;
		end else begin
			mag_e = {1'b0, quo_c[N]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_c[N];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quo_s3 <= neg_e ? -$signed(mag_e) : $signed(mag_e);
			tag_s3 <= tag_c[N][TAG_W-1:0];
		end
	end

	assign vld_o = vld_s3;
	assign quo_o = quo_s3;
	assign tag_o = tag_s3;

endmodule

// File: hdl/rmea_acos.sv
module rmea_acos #(
	parameter int STAGES = 16,
	parameter int TAG_W  = 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               vld_i,
	input  logic signed [16:0] x_i,
	input  logic [TAG_W-1:0]   tag_i,
	output logic               vld_o,
	output logic [14:0]        angle_o,
	output logic [14:0]        root_o,
	output logic [TAG_W-1:0]   tag_o
);

	localparam int NS   = STAGES > rmea_pkg::ATAN_LEN ? rmea_pkg::ATAN_LEN : STAGES;
	localparam int NQ   = rmea_pkg::SQRT_STEPS;
	localparam int SW   = rmea_pkg::SQ_W;
	localparam int STW  = TAG_W + 17;
	localparam int CTW  = TAG_W + 32;

	logic signed [33:0]     sq;
	logic                   vld_s1;
	logic [SW-1:0]          rad_s1;
	logic [STW-1:0]         tag_s1;

	logic                   qv_c [NQ+1];
	logic [SW-1:0]          rad_c [NQ+1];
	logic [SW-1:0]          root_c [NQ+1];
	logic [STW-1:0]         qt_c [NQ+1];

	logic signed [16:0]     xr;
	logic [14:0]            rt;
	logic signed [31:0]     xs;
	logic signed [31:0]     rs;

	logic                   cv_c [NS+1];
	logic signed [31:0]     cx_c [NS+1];
	logic signed [31:0]     cy_c [NS+1];
	logic signed [31:0]     cz_c [NS+1];
	logic [CTW-1:0]         ct_c [NS+1];

	logic signed [16:0]     xf;
	logic signed [31:0]     zc;
	logic signed [31:0]     rnd;
	logic [14:0]            ang_r;
	logic [14:0]            ang;

	logic                   vld_s3;
	logic [14:0]            angle_s3;
	logic [14:0]            root_s3;
	logic [TAG_W-1:0]       tag_s3;

	// Radicand one minus x squared
	assign sq = x_i * x_i;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s1 <= rmea_pkg::SQ_FULL - sq[SW-1:0];
			tag_s1 <= {x_i, tag_i};
		end
	end

	assign qv_c[0]   = vld_s1;
	assign rad_c[0]  = rad_s1;
	assign root_c[0] = '0;
	assign qt_c[0]   = tag_s1;

	// Square root row
	for (genvar g = 0; g < NQ; g++) begin : g_sqrt
		rmea_sqrt_cell #(
			.K     (NQ - 1 - g),
			.TAG_W (STW)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.vld_i  (qv_c[g]),
			.rad_i  (rad_c[g]),
			.root_i (root_c[g]),
			.tag_i  (qt_c[g]),
			.vld_o  (qv_c[g+1]),
			.rad_o  (rad_c[g+1]),
			.root_o (root_c[g+1]),
			.tag_o  (qt_c[g+1])
		);
	end

	// Seed the rotation; turn by a right angle when x is negative
	assign xr = qt_c[NQ][STW-1:TAG_W];
	assign rt = root_c[NQ][14:0];
	assign xs = 32'(xr) <<< 14;
	assign rs = $signed({17'd0, rt}) <<< 14;

	assign cv_c[0] = qv_c[NQ];
	assign cx_c[0] = xr[16] ? rs : xs;
	assign cy_c[0] = xr[16] ? -xs : rs;
	assign cz_c[0] = xr[16] ? rmea_pkg::HALF_PI_Q24 : '0;
	assign ct_c[0] = {xr, rt, qt_c[NQ][TAG_W-1:0]};

	// Vectoring row
	for (genvar g = 0; g < NS; g++) begin : g_cordic
		rmea_cordic_cell #(
			.IDX   (g),
			.TAG_W (CTW)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.vld_i  (cv_c[g]),
			.x_i    (cx_c[g]),
			.y_i    (cy_c[g]),
			.z_i    (cz_c[g]),
			.tag_i  (ct_c[g]),
			.vld_o  (cv_c[g+1]),
			.x_o    (cx_c[g+1]),
			.y_o    (cy_c[g+1]),
			.z_o    (cz_c[g+1]),
			.tag_o  (ct_c[g+1])
		);
	end

	// Clamp the angle to [0, pi] and round to Q2.13
	assign xf = ct_c[NS][CTW-1:TAG_W+15];

	always_comb begin
		if (cz_c[NS][31]) begin
			zc = '0;
		end else if (cz_c[NS] > rmea_pkg::PI_Q24) begin
			zc = rmea_pkg::PI_Q24;
		end else begin
			zc = cz_c[NS];
		end
		rnd   = zc + 32'sd1024;
		ang_r = rnd[25:11];
		ang   = ang_r > rmea_pkg::PI_Q13 ? rmea_pkg::PI_Q13 : ang_r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= cv_c[NS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			priority if (xf == rmea_pkg::ONE_Q14) begin
				angle_s3 <= '0;
			end else if (xf == rmea_pkg::NEG_ONE_Q14) begin
				angle_s3 <= rmea_pkg::PI_Q13;
			end else begin
				angle_s3 <= ang;
			end
			root_s3 <= ct_c[NS][TAG_W+14:TAG_W];
			tag_s3  <= ct_c[NS][TAG_W-1:0];
		end
	end

	assign vld_o   = vld_s3;
	assign angle_o = angle_s3;
	assign root_o  = root_s3;
	assign tag_o   = tag_s3;

endmodule

// File: hdl/rotation_matrix_to_euler_angles_unit.sv
// N = min(CORDIC_STAGES, 24) is the number of rotation cells in each arccosine row.
// Throughput: one matrix per cycle while not stalled; every stage moves with the row.
// The path runs through two arccosine rows in series (15 root cells plus N rotation cells
// each) with the 16-cell divider rows between them.
// Reset: arst_n clears all valid bits at once; no results are pending afterwards.
module rotation_matrix_to_euler_angles_unit #(
	parameter int CORDIC_STAGES = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              matrix_valid,
	output logic              matrix_stall,
	input  rmea_pkg::matrix_t matrix,
	output logic              angles_valid,
	input  logic              angles_stall,
	output rmea_pkg::angles_t angles
);

	localparam int BTW = 1 + 16 * 4 + 33 + 33 + 32;
	localparam int DTW = 1 + 15 + 32;

	logic                 adv;

	logic                 vld_s1;
	rmea_pkg::matrix_t    m_s1;

	logic signed [16:0]   r22x;
	logic signed [16:0]   cosb;
	logic                 vld_s2;
	logic signed [16:0]   cosb_s2;
	logic signed [15:0]   r00_s2, r01_s2, r02_s2, r12_s2;
	logic signed [31:0]   p_ca_s2, p_cb_s2, p_sa_s2, p_sb_s2, p_qa_s2, p_qb_s2;

	logic                 vld_s3;
	logic signed [16:0]   cosb_s3;
	logic                 degen_s3;
	logic signed [15:0]   r00_s3, r01_s3, r02_s3, r12_s3;
	logic signed [32:0]   numc_cos_s3;
	logic signed [32:0]   numc_sin_s3;
	logic [31:0]          den_c_s3;

	logic                 bv;
	logic [14:0]          b_ang;
	logic [14:0]          sinb;
	logic [BTW-1:0]       b_tag;
	logic                 b_degen;
	logic signed [15:0]   b_r00, b_r01, b_r02, b_r12;
	logic signed [32:0]   b_ncos, b_nsin;
	logic [31:0]          b_den;

	logic                 dv;
	logic signed [16:0]   qa_cos, qa_sin, qc_cos, qc_sin;
	logic [DTW-1:0]       d_tag;
	logic                 d_degen;
	logic [14:0]          d_b;
	logic signed [15:0]   d_r00, d_r01;

	rmea_pkg::pair_t      pa;
	rmea_pkg::pair_t      pc;

	logic                 vld_s4;
	logic signed [16:0]   co_a_s4, co_c_s4;
	logic                 neg_a_s4, neg_c_s4;
	logic                 degen_s4;
	logic [14:0]          b_s4;

	logic                 av;
	logic [14:0]          a_ang;
	logic [16:0]          a_tag;
	logic [14:0]          c_ang;
	logic                 c_tag;
	logic signed [15:0]   a_mag, c_mag;

	logic                 out_valid_q;
	rmea_pkg::angles_t    out_q;

	// Move the whole row whenever the output register is free or being drained
	assign adv          = !out_valid_q || !angles_stall;
	assign matrix_stall = !adv;

	// Stage 1: capture the matrix beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			vld_s1 <= matrix_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			out_valid_q <= av;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_s1 <= matrix;
		end
	end

	// Stage 2: clamp r22 and form the products
	assign r22x = 17'(m_s1.r22);

	always_comb begin
		if (r22x > rmea_pkg::ONE_Q14) begin
			cosb = rmea_pkg::ONE_Q14;
		end else if (r22x < rmea_pkg::NEG_ONE_Q14) begin
			cosb = rmea_pkg::NEG_ONE_Q14;
		end else begin
			cosb = r22x;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cosb_s2 <= cosb;
			r00_s2  <= m_s1.r00;
			r01_s2  <= m_s1.r01;
			r02_s2  <= m_s1.r02;
			r12_s2  <= m_s1.r12;
			p_ca_s2 <= m_s1.r02 * m_s1.r20;
			p_cb_s2 <= m_s1.r12 * m_s1.r21;
			p_sa_s2 <= m_s1.r21 * m_s1.r02;
			p_sb_s2 <= m_s1.r20 * m_s1.r12;
			p_qa_s2 <= m_s1.r02 * m_s1.r02;
			p_qb_s2 <= m_s1.r12 * m_s1.r12;
		end
	end

	// Stage 3: numerators and the sum of squares for c
	always_ff @(posedge clk) begin
		if (adv) begin
			cosb_s3     <= cosb_s2;
			degen_s3    <= cosb_s2 == rmea_pkg::ONE_Q14;
			r00_s3      <= r00_s2;
			r01_s3      <= r01_s2;
			r02_s3      <= r02_s2;
			r12_s3      <= r12_s2;
			numc_cos_s3 <= -(33'(p_ca_s2) + 33'(p_cb_s2));
			numc_sin_s3 <= 33'(p_sa_s2) - 33'(p_sb_s2);
			den_c_s3    <= 32'(p_qa_s2) + 32'(p_qb_s2);
		end
	end

	// Angle b; its root is sin(b)
	rmea_acos #(
		.STAGES (CORDIC_STAGES),
		.TAG_W  (BTW)
	) u_acos_b (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.vld_i   (vld_s3),
		.x_i     (cosb_s3),
		.tag_i   ({degen_s3, r00_s3, r01_s3, r02_s3, r12_s3,
			numc_cos_s3, numc_sin_s3, den_c_s3}),
		.vld_o   (bv),
		.angle_o (b_ang),
		.root_o  (sinb),
		.tag_o   (b_tag)
	);

	assign {b_degen, b_r00, b_r01, b_r02, b_r12, b_ncos, b_nsin, b_den} = b_tag;

	// Quotients for the cosine and sine of a and c
	rmea_divider #(
		.TAG_W (DTW)
	) u_div_acos (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.vld_i  (bv),
		.num_i  (33'(b_r02)),
		.den_i  (32'(sinb)),
		.tag_i  ({b_degen, b_ang, b_r00, b_r01}),
		.vld_o  (dv),
		.quo_o  (qa_cos),
		.tag_o  (d_tag)
	);

	rmea_divider #(
		.TAG_W (1)
	) u_div_asin (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.vld_i  (bv),
		.num_i  (33'(b_r12)),
		.den_i  (32'(sinb)),
		.tag_i  (1'b0),
		.vld_o  (),
		.quo_o  (qa_sin),
		.tag_o  ()
	);

	rmea_divider #(
		.TAG_W (1)
	) u_div_ccos (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.vld_i  (bv),
		.num_i  (b_ncos),
		.den_i  (b_den),
		.tag_i  (1'b0),
		.vld_o  (),
		.quo_o  (qc_cos),
		.tag_o  ()
	);

	rmea_divider #(
		.TAG_W (1)
	) u_div_csin (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.vld_i  (bv),
		.num_i  (b_nsin),
		.den_i  (b_den),
		.tag_i  (1'b0),
		.vld_o  (),
		.quo_o  (qc_sin),
		.tag_o  ()
	);

	assign {d_degen, d_b, d_r00, d_r01} = d_tag;

	// Stage 4: clamp the pairs; c takes the first row when b is zero
	assign pa = rmea_pkg::pair_clamp(qa_cos, qa_sin);
	assign pc = d_degen ? rmea_pkg::pair_clamp(17'(d_r00), 17'(d_r01))
		: rmea_pkg::pair_clamp(qc_cos, qc_sin);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s4 <= dv;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			co_a_s4  <= pa.co;
			neg_a_s4 <= pa.neg;
			co_c_s4  <= pc.co;
			neg_c_s4 <= pc.neg;
			degen_s4 <= d_degen;
			b_s4     <= d_b;
		end
	end

	rmea_acos #(
		.STAGES (CORDIC_STAGES),
		.TAG_W  (17)
	) u_acos_a (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.vld_i   (vld_s4),
		.x_i     (co_a_s4),
		.tag_i   ({degen_s4, b_s4, neg_a_s4}),
		.vld_o   (av),
		.angle_o (a_ang),
		.root_o  (),
		.tag_o   (a_tag)
	);

	rmea_acos #(
		.STAGES (CORDIC_STAGES),
		.TAG_W  (1)
	) u_acos_c (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.vld_i   (vld_s4),
		.x_i     (co_c_s4),
		.tag_i   (neg_c_s4),
		.vld_o   (),
		.angle_o (c_ang),
		.root_o  (),
		.tag_o   (c_tag)
	);

	// Output register: apply the signs, and zero a and b for a degenerate matrix
	assign a_mag = $signed({1'b0, a_ang});
	assign c_mag = $signed({1'b0, c_ang});

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q.angle_a    <= a_tag[16] ? '0 : (a_tag[0] ? -a_mag : a_mag);
			out_q.angle_b    <= a_tag[16] ? '0 : a_tag[15:1];
			out_q.angle_c    <= c_tag ? -c_mag : c_mag;
			out_q.degenerate <= a_tag[16];
		end
	end

	assign angles_valid = out_valid_q;
	assign angles       = out_q;

	// The input side stalls only behind a held result
	assert property (@(posedge clk) disable iff (!arst_n)
		matrix_stall |-> angles_valid)
		else $error("input stalled with no result pending");

	assert property (@(posedge clk) disable iff (!arst_n)
		angles_valid && angles.degenerate |-> angles.angle_a == '0 && angles.angle_b == '0)
		else $error("degenerate result with nonzero a or b");

	assert property (@(posedge clk) disable iff (!arst_n)
		angles_valid |-> angles.angle_b <= rmea_pkg::PI_Q13)
		else $error("angle b above pi");

	assert property (@(posedge clk) disable iff (!arst_n)
		angles_valid && angles_stall |=> angles_valid)
		else $error("held result lost");

endmodule
